/* rtl/oat_pkg.sv */
// Package for the outstanding ack tracker.
// Holds the item structs, the per-cell control struct and the command codes.
// No dependencies.
package oat_pkg;

	localparam int ID_W   = 32;
	localparam int PEND_W = 7;

	localparam logic CMD_SEND = 1'b0;
	localparam logic CMD_ACK  = 1'b1;

	typedef struct packed {
		logic            cmd;
		logic [ID_W-1:0] cmd_id;
	} in_item_t;

	typedef struct packed {
		logic              accepted;
		logic              error_flag;
		logic [ID_W-1:0]   error_id;
		logic [PEND_W-1:0] pending;
	} out_item_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

endpackage

/* rtl/outstanding_ack_tracker.sv */
// Outstanding ack tracker: an ordered list of command ids awaiting acknowledgement,
// kept in a row of cells with the head in cell 0. A send, a matching ack or an ack
// with id 0 needs no search: its result strobes on done in the cycle after start,
// and busy stays low. An ack that mismatches the head drops that entry and keeps busy
// high while it drops further entries until the head matches or the list is empty;
// then its error result strobes on done. The list moves forward one entry per cycle
// through the cell chain. Results cannot be held off. cfg_ready is always high.
module outstanding_ack_tracker #(
	parameter int LIST_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  oat_pkg::in_item_t   item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data,
	output logic                done,
	output oat_pkg::out_item_t  result
);

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int ID_W  = oat_pkg::ID_W;

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_SEARCH = 1'b1;

	logic                state_q, state_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic                master_q;
	logic [ID_W-1:0]     ack_id_q;
	logic [ID_W-1:0]     err_id_q;
	logic                done_q;
	oat_pkg::out_item_t  result_q, res_d;
	logic                res_load;
	logic                shift;
	logic                append;
	logic                accept;
	logic                full;
	logic                head_match;
	logic                search_end;
	logic [ID_W-1:0]     ids [LIST_DEPTH];
	logic [oat_pkg::PEND_W+CNT_W-1:0] cnt_ext;

	assign accept     = start && !busy;
	assign busy       = (state_q == ST_SEARCH);
	assign cfg_ready  = 1'b1;
	assign full       = (cnt_q == CNT_W'(LIST_DEPTH));
	assign head_match = (ids[0] == item.cmd_id);
	assign search_end = (cnt_q == '0) || (ids[0] == ack_id_q);
	assign cnt_ext    = {{oat_pkg::PEND_W{1'b0}}, cnt_d};

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		shift    = 1'b0;
		append   = 1'b0;
		res_load = 1'b0;
		res_d    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_load = 1'b1;
					if (item.cmd == oat_pkg::CMD_SEND) begin
						if (full) begin
							res_d.error_flag = (item.cmd_id != '0);
							res_d.error_id   = item.cmd_id;
						end else begin
							res_d.accepted = 1'b1;
							if (master_q && (item.cmd_id != '0)) begin
								append = 1'b1;
								cnt_d  = cnt_q + CNT_W'(1);
							end
						end
					end else if (item.cmd_id != '0) begin
						if (cnt_q == '0) begin
							res_d.error_flag = 1'b1;
						end else if (head_match) begin
							shift = 1'b1;
							cnt_d = cnt_q - CNT_W'(1);
						end else begin
							// Mismatch: the head is dropped now, the rest is searched.
							shift    = 1'b1;
							cnt_d    = cnt_q - CNT_W'(1);
							res_load = 1'b0;
							state_d  = ST_SEARCH;
						end
					end
				end
			end
			ST_SEARCH: begin
				if (search_end) begin
					res_load         = 1'b1;
					res_d.error_flag = 1'b1;
					res_d.error_id   = err_id_q;
					state_d          = ST_IDLE;
				end else begin
					shift = 1'b1;
					cnt_d = cnt_q - CNT_W'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		res_d.pending = cnt_ext[oat_pkg::PEND_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			master_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= res_load;
			if (cfg_valid && cfg_ready) begin
				master_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			result_q <= res_d;
		end
		if (accept) begin
			ack_id_q <= item.cmd_id;
			err_id_q <= ids[0];
		end
	end

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		oat_pkg::cell_ctrl_t ctrl;
		logic [ID_W-1:0]     next_id;

		assign ctrl.shift = shift;
		assign ctrl.load  = append && (cnt_q == CNT_W'(i));
		if (i == LIST_DEPTH - 1) begin : g_tail
			assign next_id = ids[i];
		end else begin : g_body
			assign next_id = ids[i+1];
		end

		oat_cell u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.new_id  (item.cmd_id),
			.next_id (next_id),
			.id      (ids[i])
		);
	end

	assign done   = done_q;
	assign result = result_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(LIST_DEPTH))
		else $error("list count exceeds depth");

	a_search_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) && !search_end |=> cnt_q == $past(cnt_q) - CNT_W'(1))
		else $error("search step did not drop one entry");

	a_accept_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.accepted |-> !result.error_flag)
		else $error("accepted send item reported an error");

	a_search_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) && search_end |=> done && result.error_flag)
		else $error("search ended without an error result");

endmodule

/* rtl/oat_cell.sv */
// One entry of the tracker's id list.
// Depends on oat_pkg for the id width and the cell control struct.
module oat_cell (
	input  logic                     clk,
	input  oat_pkg::cell_ctrl_t      ctrl,
	input  logic [oat_pkg::ID_W-1:0] new_id,
	input  logic [oat_pkg::ID_W-1:0] next_id,
	output logic [oat_pkg::ID_W-1:0] id
);

	logic [oat_pkg::ID_W-1:0] id_q;

	// A shift takes the entry from the neighbor behind; a load appends a new id.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			id_q <= next_id;
		end else if (ctrl.load) begin
			id_q <= new_id;
		end
	end

	assign id = id_q;

endmodule
